>>> design/rfc_pkg.sv
package rfc_pkg;

    // Frame constants.
    localparam logic [7:0] STUFF_MARK   = 8'hAA;
    localparam logic [7:0] SUM_START_M1 = 8'hA1;
    localparam logic [7:0] TYPE_A       = 8'hC1;
    localparam logic [7:0] TYPE_B       = 8'hC4;
    localparam logic [7:0] FIXED_INDEX  = 8'h01;

    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROTOCOL_MODE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALL_PARAMS_CODE = 1'b1;

    // Protocol modes.
    localparam logic MODE_STUFFED = 1'b0;
    localparam logic MODE_PLAIN   = 1'b1;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK           = 2'd0;
    localparam status_t STATUS_CHECKSUM_ERR = 2'd1;
    localparam status_t STATUS_UNKNOWN_TYPE = 2'd2;
    localparam status_t STATUS_BAD_LENGTH   = 2'd3;

endpackage

>>> design/response_frame_checker.sv
// Channel   Direction  Handshake               Payload
// --------  ---------  ----------------------  ---------------------------------------------
// in        sink       in_valid / in_ready     raw_byte, frame_end
// out       source     out_valid / out_ready   status, transmitter_index, transmitter_type,
//                                              request_code, frame_length
// cfg       sink       cfg_write_en            cfg_index, cfg_data
//
// One word is taken per clock cycle while in_ready is high; the frame state
// (stuffing flag, byte count, length, running checksum and header bytes)
// updates in the cycle the word is accepted.
// The result appears on the out channel the cycle after the last word of a
// frame is accepted, from a single result register.
// in_ready drops only while that result register is full and out_ready is low.
// Reset clears the frame state, the configuration registers and out_valid.
module response_frame_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           raw_byte,
    input  logic                                 frame_end,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output rfc_pkg::status_t                     status,
    output logic [7:0]                           transmitter_index,
    output logic [7:0]                           transmitter_type,
    output logic [7:0]                           request_code,
    output logic [15:0]                          frame_length,

    input  logic                                 cfg_write_en,
    input  logic [rfc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [7:0]                           cfg_data
);

    // Configuration registers.
    logic       mode_reg;
    logic [7:0] params_code_reg;

    // Frame state.
    logic                         skip_reg, skip_next;
    logic [rfc_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [15:0]                  length_reg, length_next;
    logic [7:0]                   sum_reg, sum_next;
    logic                         matched_reg, matched_next;
    logic [7:0]                   hdr_index_reg, hdr_index_next;
    logic [7:0]                   hdr_type_reg, hdr_type_next;
    logic [7:0]                   hdr_code_reg, hdr_code_next;

    // Result register.
    logic              out_valid_reg;
    rfc_pkg::status_t  status_reg, status_next;
    logic [7:0]        index_out_reg, index_out_next;
    logic [7:0]        type_out_reg, type_out_next;
    logic [7:0]        code_out_reg, code_out_next;
    logic [15:0]       length_out_reg;

    logic        accept;
    logic        keep;
    logic [7:0]  add_base;
    logic [8:0]  add_wide;
    logic [7:0]  add_result;
    logic [16:0] last_pos;

    // The result register is free when empty or when its word leaves now.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= rfc_pkg::MODE_STUFFED;
            params_code_reg <= 8'd0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                rfc_pkg::CFG_PROTOCOL_MODE:   mode_reg        <= cfg_data[0];
                rfc_pkg::CFG_ALL_PARAMS_CODE: params_code_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // A byte is kept unless it follows a stuffing mark in the stuffed mode.
    // In the plain mode any pending skip is dropped and the byte is kept.
    assign keep = (mode_reg == rfc_pkg::MODE_PLAIN) || !skip_reg;

    // The first kept byte starts the sum from the mode's start value.
    assign add_base = (count_reg == '0)
                    ? ((mode_reg == rfc_pkg::MODE_PLAIN) ? rfc_pkg::SUM_START_M1 : 8'd0)
                    : sum_reg;
    assign add_wide = {1'b0, add_base} + {1'b0, raw_byte};
    // End-around carry in the plain mode; the low byte is at most 0xFE when
    // a carry is out, so adding it back never overflows again.
    assign add_result = add_wide[7:0]
                      + {7'd0, (mode_reg == rfc_pkg::MODE_PLAIN) && add_wide[8]};

    always_comb
    begin
        skip_next      = skip_reg;
        count_next     = count_reg;
        length_next    = length_reg;
        sum_next       = sum_reg;
        matched_next   = matched_reg;
        hdr_index_next = hdr_index_reg;
        hdr_type_next  = hdr_type_reg;
        hdr_code_next  = hdr_code_reg;
        last_pos       = '0;

        if (mode_reg == rfc_pkg::MODE_PLAIN)
            skip_next = 1'b0;
        else if (skip_reg)
            skip_next = 1'b0;
        else
            skip_next = (raw_byte == rfc_pkg::STUFF_MARK);

        if (keep)
        begin
            if (count_reg == '0)
            begin
                length_next = {raw_byte, length_reg[7:0]};
                sum_next    = add_result;
            end
            else
            begin
                if (count_reg == 16'd1)
                    length_next = {length_reg[15:8], raw_byte};
                if (count_reg == 16'd2)
                    hdr_index_next = raw_byte;
                if (count_reg == 16'd3)
                    hdr_type_next = raw_byte;
                if (count_reg == 16'd4)
                    hdr_code_next = raw_byte;

                // The checksum byte sits at position length - 1; the compare
                // sees the length including a low byte taken in this cycle.
                last_pos = {1'b0, length_next} - 17'd1;
                if (length_next != 16'd0)
                begin
                    if ({1'b0, count_reg} < last_pos)
                        sum_next = add_result;
                    else if ({1'b0, count_reg} == last_pos)
                        matched_next = (sum_reg == raw_byte);
                end
            end

            if (count_reg != rfc_pkg::COUNT_MAX)
                count_next = count_reg + 16'd1;
        end
    end

    // Result fields, taken from the state as it stands after this byte.
    always_comb
    begin
        if (mode_reg == rfc_pkg::MODE_STUFFED)
        begin
            index_out_next = hdr_index_next;
            type_out_next  = hdr_type_next;
            code_out_next  = hdr_code_next;
        end
        else
        begin
            index_out_next = rfc_pkg::FIXED_INDEX;
            type_out_next  = rfc_pkg::TYPE_A;
            code_out_next  = params_code_reg;
        end

        if (length_next < 16'd2 || length_next > count_next)
            status_next = rfc_pkg::STATUS_BAD_LENGTH;
        else if (!matched_next)
            status_next = rfc_pkg::STATUS_CHECKSUM_ERR;
        else if (type_out_next != rfc_pkg::TYPE_A && type_out_next != rfc_pkg::TYPE_B)
            status_next = rfc_pkg::STATUS_UNKNOWN_TYPE;
        else
            status_next = rfc_pkg::STATUS_OK;
    end

    // Frame state: updated per accepted word, cleared after the last word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg      <= 1'b0;
            count_reg     <= '0;
            length_reg    <= 16'd0;
            sum_reg       <= 8'd0;
            matched_reg   <= 1'b0;
            hdr_index_reg <= 8'd0;
            hdr_type_reg  <= 8'd0;
            hdr_code_reg  <= 8'd0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                skip_reg      <= 1'b0;
                count_reg     <= '0;
                length_reg    <= 16'd0;
                sum_reg       <= 8'd0;
                matched_reg   <= 1'b0;
                hdr_index_reg <= 8'd0;
                hdr_type_reg  <= 8'd0;
                hdr_code_reg  <= 8'd0;
            end
            else
            begin
                skip_reg      <= skip_next;
                count_reg     <= count_next;
                length_reg    <= length_next;
                sum_reg       <= sum_next;
                matched_reg   <= matched_next;
                hdr_index_reg <= hdr_index_next;
                hdr_type_reg  <= hdr_type_next;
                hdr_code_reg  <= hdr_code_next;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && frame_end)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload, loaded only when a frame ends.
    always_ff @(posedge clk)
    begin
        if (accept && frame_end)
        begin
            status_reg     <= status_next;
            index_out_reg  <= index_out_next;
            type_out_reg   <= type_out_next;
            code_out_reg   <= code_out_next;
            length_out_reg <= length_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign transmitter_index = index_out_reg;
    assign transmitter_type  = type_out_reg;
    assign request_code      = code_out_reg;
    assign frame_length      = length_out_reg;

    // The last word of a frame always produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_end |=> out_valid_reg)
        else $error("frame end did not produce a result");

    // The frame state starts over after the last word.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_end |=> count_reg == '0 && !skip_reg && !matched_reg)
        else $error("frame state not cleared after frame end");

    // A pending skip only follows a kept stuffing mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> count_reg != '0)
        else $error("skip pending with no kept byte");

    // A held result blocks new words.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !in_ready)
        else $error("word accepted while result is held");

    // A good result never carries a length below two.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(status_reg == rfc_pkg::STATUS_OK && length_out_reg < 16'd2))
        else $error("ok status with a bad length");

endmodule

>>> tb/response_frame_checker_tb.sv
module response_frame_checker_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycle limit for the whole run; this only stops a hang.
    localparam int unsigned CYCLE_LIMIT = 200_000;

    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 300;

    // One result word as the block reports it at the end of a frame.
    typedef struct {
        rfc_pkg::status_t status;
        logic [7:0] index;
        logic [7:0] ftype;
        logic [7:0] code;
        logic [15:0] length;
    } frame_verdict_t;

    // Scoreboard: tracks the frame the block is parsing, word by word, and
    // keeps the verdicts that are still to come out of the block, oldest
    // first.
    class frame_verdict_board;
        logic        mode;
        logic [7:0]  params_code;
        bit          skip_pending;
        logic [15:0] kept_count;
        logic [15:0] length_word;
        logic [7:0]  running_sum;
        bit          sum_ok;
        logic [7:0]  hdr_index;
        logic [7:0]  hdr_type;
        logic [7:0]  hdr_code;
        frame_verdict_t verdicts[$];
        int          errors;

        function new();
            mode = rfc_pkg::MODE_STUFFED;
            params_code = 8'h00;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            skip_pending = 1'b0;
            kept_count = '0;
            length_word = '0;
            running_sum = '0;
            sum_ok = 1'b0;
            hdr_index = '0;
            hdr_type = '0;
            hdr_code = '0;
        endfunction

        // In plain mode a carry out of the byte is folded back in.
        function logic [7:0] fold(logic [7:0] acc, logic [7:0] b);
            logic [8:0] s;
            s = {1'b0, acc} + {1'b0, b};
            if (mode == rfc_pkg::MODE_PLAIN && s[8])
                s = s + 9'd1;
            return s[7:0];
        endfunction

        function void keep_byte(logic [7:0] b);
            int n;
            int last_pos;
            n = int'(kept_count);
            if (n == 0) begin
                length_word[15:8] = b;
                running_sum = fold((mode == rfc_pkg::MODE_PLAIN) ? rfc_pkg::SUM_START_M1
                                                                  : 8'h00, b);
            end
            else begin
                case (n)
                    1: length_word[7:0] = b;
                    2: hdr_index = b;
                    3: hdr_type = b;
                    4: hdr_code = b;
                    default: ;
                endcase
                if (length_word >= 16'd1) begin
                    last_pos = int'(length_word) - 1;
                    if (n < last_pos)
                        running_sum = fold(running_sum, b);
                    else if (n == last_pos)
                        sum_ok = (running_sum == b);
                end
            end
            if (kept_count != rfc_pkg::COUNT_MAX)
                kept_count = kept_count + 16'd1;
        endfunction

        function void write_reg(logic [rfc_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] data);
            if (idx == rfc_pkg::CFG_PROTOCOL_MODE)
                mode = data[0];
            else if (idx == rfc_pkg::CFG_ALL_PARAMS_CODE)
                params_code = data;
        endfunction

        function void note_word(logic [7:0] b, logic last);
            frame_verdict_t v;
            if (mode == rfc_pkg::MODE_STUFFED) begin
                if (skip_pending)
                    skip_pending = 1'b0;
                else begin
                    keep_byte(b);
                    if (b == rfc_pkg::STUFF_MARK)
                        skip_pending = 1'b1;
                end
            end
            else begin
                skip_pending = 1'b0;
                keep_byte(b);
            end
            if (last) begin
                if (mode == rfc_pkg::MODE_STUFFED) begin
                    v.index = hdr_index;
                    v.ftype = hdr_type;
                    v.code = hdr_code;
                end
                else begin
                    v.index = rfc_pkg::FIXED_INDEX;
                    v.ftype = rfc_pkg::TYPE_A;
                    v.code = params_code;
                end
                v.length = length_word;
                if (length_word < 16'd2 || length_word > kept_count)
                    v.status = rfc_pkg::STATUS_BAD_LENGTH;
                else if (!sum_ok)
                    v.status = rfc_pkg::STATUS_CHECKSUM_ERR;
                else if (v.ftype != rfc_pkg::TYPE_A && v.ftype != rfc_pkg::TYPE_B)
                    v.status = rfc_pkg::STATUS_UNKNOWN_TYPE;
                else
                    v.status = rfc_pkg::STATUS_OK;
                verdicts.push_back(v);
                clear_frame();
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_verdict(frame_verdict_t got);
            frame_verdict_t want;
            if (verdicts.size() == 0) begin
                $display("%0t: result word with no frame pending: %s %0d length %h",
                         $time, "expected none, got status", got.status, got.length);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("transmitter_index", 16'(want.index), 16'(got.index));
            compare_field("transmitter_type", 16'(want.ftype), 16'(got.ftype));
            compare_field("request_code", 16'(want.code), 16'(got.code));
            compare_field("frame_length", want.length, got.length);
        endfunction

        function int outstanding();
            return verdicts.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  raw_byte;
    logic        frame_end;
    logic        out_valid;
    logic        out_ready;
    rfc_pkg::status_t status;
    logic [7:0]  transmitter_index;
    logic [7:0]  transmitter_type;
    logic [7:0]  request_code;
    logic [15:0] frame_length;
    logic        cfg_write_en;
    logic [rfc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]  cfg_data;

    frame_verdict_board sb;

    // Mode the block was last set to; decides whether the sender stuffs.
    logic        cur_mode = rfc_pkg::MODE_STUFFED;
    // Sender pacing: longest gap between bursts, and words left in the burst.
    int          gap_max = 0;
    int          burst_left = 0;
    int          words_offered = 0;
    // Receiver pacing: percentage of cycles with out_ready low.
    int          stall_pct = 0;
    // The stimulus raises hold_asked; the receiver answers by holding off.
    int          hold_asked = 0;
    int          hold_done = 0;

    // Unstuffed bytes of the frame being sent.
    logic [7:0]  frame_bytes[$];

    response_frame_checker i_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .raw_byte          (raw_byte),
        .frame_end         (frame_end),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .transmitter_index (transmitter_index),
        .transmitter_type  (transmitter_type),
        .request_code      (request_code),
        .frame_length      (frame_length),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // All handshakes are observed here at the rising edge. Inputs only move
    // at the falling edge, so everything read here is settled. A result is
    // checked before a new frame end is noted, which keeps the queue in
    // order when both happen at the same edge.
    always @(posedge clk)
    begin : monitor
        frame_verdict_t got;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got.status = status;
                got.index = transmitter_index;
                got.ftype = transmitter_type;
                got.code = request_code;
                got.length = frame_length;
                sb.check_verdict(got);
            end
            if (cfg_write_en)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_word(raw_byte, frame_end);
        end
    end

    // Receiver. Stalls at random with the rate the stimulus sets, but opens
    // up completely whenever bits 6:4 of its cycle count are zero, so that
    // back-to-back results are also seen. When asked, it holds off for a long
    // stretch so the result register fills and the block stalls its input.
    initial
    begin : receiver
        int rx_cycle;
        rx_cycle = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            rx_cycle++;
            if (hold_asked != hold_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done++;
            end
            else if (rx_cycle[6:4] == 3'd0)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("** response_frame_checker: FAILED **");
        $finish;
    end

    // Offers one word and returns at the edge where it is taken. A new
    // burst starts with a random gap, during which valid is low.
    task automatic offer_word(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        raw_byte <= b;
        frame_end <= last;
        words_offered++;
        forever begin
            @(posedge clk);
            if (in_ready)
                break;
        end
    endtask

    // Stops sending and waits until every verdict is out. A frame in
    // progress is simply left open; its state stays in the block.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rfc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Both registers are rewritten each time. The mode register only looks
    // at bit 0, so the upper bits carry junk.
    task automatic set_registers(input logic mode, input logic [7:0] code);
        logic [6:0] junk;
        wait_idle();
        junk = 7'($urandom);
        write_reg(rfc_pkg::CFG_PROTOCOL_MODE, {junk, mode});
        write_reg(rfc_pkg::CFG_ALL_PARAMS_CODE, code);
        cur_mode = mode;
    endtask

    // Builds the unstuffed bytes of a frame: length field, header bytes and,
    // where the length fits, a checksum in byte len_val-1 computed for the
    // current mode. Filler bytes lean toward the stuffing mark.
    task automatic build_frame(input int len_val, input int count,
                               input logic [7:0] index_val, input logic [7:0] type_val,
                               input bit spoil);
        logic [7:0] fill;
        logic [7:0] acc;
        logic [7:0] flip;
        logic [8:0] s;
        int i;
        frame_bytes.delete();
        for (i = 0; i < count; i++) begin
            fill = 8'($urandom);
            if ($urandom_range(0, 7) == 0)
                fill = rfc_pkg::STUFF_MARK;
            frame_bytes.push_back(fill);
        end
        if (count > 0) frame_bytes[0] = len_val[15:8];
        if (count > 1) frame_bytes[1] = len_val[7:0];
        if (count > 2) frame_bytes[2] = index_val;
        if (count > 3) frame_bytes[3] = type_val;
        if (len_val >= 3 && len_val <= count) begin
            acc = (cur_mode == rfc_pkg::MODE_PLAIN) ? rfc_pkg::SUM_START_M1 : 8'h00;
            for (i = 0; i < len_val - 1; i++) begin
                s = {1'b0, acc} + {1'b0, frame_bytes[i]};
                if (cur_mode == rfc_pkg::MODE_PLAIN && s[8])
                    s = s + 9'd1;
                acc = s[7:0];
            end
            flip = 8'($urandom_range(1, 255));
            frame_bytes[len_val - 1] = spoil ? (acc ^ flip) : acc;
        end
    endtask

    // Sends frame_bytes from position from_i on, stuffing in stuffed mode.
    // A mark in the last position gets a filler after it only when
    // tail_random allows it and the coin says so.
    task automatic send_frame(input int from_i, input bit tail_random);
        int n;
        int i;
        bit filler;
        n = frame_bytes.size();
        for (i = from_i; i < n; i++) begin
            filler = (cur_mode == rfc_pkg::MODE_STUFFED) &&
                     (frame_bytes[i] == rfc_pkg::STUFF_MARK) &&
                     ((i < n - 1) || (tail_random && ($urandom_range(0, 1) == 1)));
            offer_word(frame_bytes[i], !filler && (i == n - 1));
            if (filler)
                offer_word(8'($urandom), i == n - 1);
        end
    endtask

    // Mostly well-formed frames with random content, plus broken ones
    // (bad sum, short or oversized length) and raw noise.
    task automatic random_frame();
        int pick;
        int len_val;
        int count;
        int n;
        int k;
        logic [7:0] ftype;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0: ftype = rfc_pkg::TYPE_A;
            1: ftype = rfc_pkg::TYPE_B;
            default: ftype = 8'($urandom);
        endcase
        len_val = $urandom_range(2, 16);
        count = len_val + $urandom_range(0, 3);
        if (pick < 10) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
                offer_word(8'($urandom), k == n - 1);
        end
        else begin
            if (pick < 16)
                build_frame(len_val, count, 8'($urandom), ftype, 1'b1);
            else if (pick < 20)
                build_frame($urandom_range(0, 1), $urandom_range(1, 8), 8'($urandom), ftype,
                            1'b0);
            else if (pick < 24)
                build_frame(len_val, len_val - $urandom_range(1, len_val - 1), 8'($urandom),
                            ftype, 1'b0);
            else if (pick < 27)
                build_frame($urandom_range(0, 65535), $urandom_range(1, 10), 8'($urandom),
                            ftype, 1'b0);
            else
                build_frame(len_val, count, 8'($urandom), ftype, 1'b0);
            send_frame(0, 1'b1);
        end
    endtask

    task automatic run_frames(input int n_words);
        int stop_at;
        stop_at = words_offered + n_words;
        while (words_offered < stop_at)
            random_frame();
    endtask

    initial
    begin : stimulus
        int i;
        in_valid = 1'b0;
        raw_byte = 8'h00;
        frame_end = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = rfc_pkg::CFG_PROTOCOL_MODE;
        cfg_data = 8'h00;
        rst_n = 1'b0;
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames, stuffed mode first.
        set_registers(rfc_pkg::MODE_STUFFED, 8'h00);
        gap_max = 2;
        stall_pct = 30;
        // A lone word: only the high length byte arrives, so the length reads as 0xFF00.
        offer_word(8'hFF, 1'b1);
        build_frame(5, 5, 8'h12, rfc_pkg::TYPE_A, 1'b0);
        send_frame(0, 1'b1);
        // The index byte is the stuffing mark, so a filler follows it.
        build_frame(6, 7, rfc_pkg::STUFF_MARK, rfc_pkg::TYPE_B, 1'b0);
        send_frame(0, 1'b1);
        // Unknown type.
        build_frame(6, 6, 8'h00, 8'h00, 1'b0);
        send_frame(0, 1'b1);
        // Checksum error.
        build_frame(6, 6, 8'hFF, rfc_pkg::TYPE_A, 1'b1);
        send_frame(0, 1'b1);
        // Length far beyond what arrives.
        build_frame(16'hFFFF, 3, 8'h00, rfc_pkg::TYPE_A, 1'b0);
        send_frame(0, 1'b1);
        // The last word is a stuffing mark with nothing after it.
        build_frame(5, 6, 8'h5A, rfc_pkg::TYPE_B, 1'b0);
        frame_bytes[5] = rfc_pkg::STUFF_MARK;
        send_frame(0, 1'b0);
        // Mode change in the middle of a frame: the third word leaves a skip
        // pending in stuffed mode, then plain mode keeps the next byte.
        build_frame(8, 9, rfc_pkg::STUFF_MARK, rfc_pkg::TYPE_A, 1'b0);
        for (i = 0; i < 3; i++)
            offer_word(frame_bytes[i], 1'b0);
        set_registers(rfc_pkg::MODE_PLAIN, 8'hFF);
        send_frame(3, 1'b1);
        // Plain mode keeps a stuffing mark as data.
        build_frame(6, 6, rfc_pkg::STUFF_MARK, rfc_pkg::TYPE_B, 1'b0);
        send_frame(0, 1'b1);

        // Random part, several register settings.
        set_registers(rfc_pkg::MODE_STUFFED, 8'h00);
        gap_max = 6;
        stall_pct = 40;
        run_frames(60);
        // The sender pauses until every verdict is out, then goes on.
        wait_idle();
        run_frames(50);

        set_registers(rfc_pkg::MODE_PLAIN, 8'hFF);
        gap_max = 3;
        stall_pct = 20;
        run_frames(110);

        // No idling on either side, then a long receiver hold-off while the
        // sender keeps pushing words.
        set_registers(rfc_pkg::MODE_STUFFED, 8'($urandom));
        gap_max = 0;
        stall_pct = 0;
        run_frames(30);
        hold_asked++;
        run_frames(120);

        set_registers(rfc_pkg::MODE_PLAIN, 8'($urandom));
        gap_max = 4;
        stall_pct = 75;
        run_frames(100);

        set_registers(rfc_pkg::MODE_STUFFED, 8'($urandom));
        gap_max = 2;
        stall_pct = 10;
        run_frames(60);

        set_registers(rfc_pkg::MODE_PLAIN, 8'h00);
        gap_max = 1;
        stall_pct = 50;
        run_frames(70);

        wait_idle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("** response_frame_checker: PASSED **");
        else
            $display("** response_frame_checker: FAILED **");
        $finish;
    end

endmodule

>>> files.f
design/rfc_pkg.sv
design/response_frame_checker.sv
tb/response_frame_checker_tb.sv
